// File: rtl/mmsd_pkg.sv
// ----------------------------------------------------------------------------
// mmsd_pkg
// Shared types, codes and helpers of the string deobfuscator.
// ----------------------------------------------------------------------------
package mmsd_pkg;

    localparam int VAL_W       = 64;
    localparam int NUM_W       = 24;
    localparam int CNT_W       = 25;
    localparam int KLEN_W      = 9;
    localparam int PADDR_W     = 6;
    localparam int PDATA_W     = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int KEY_BYTES_DEF        = 256;
    localparam int MAX_STRING_BYTES_DEF = 16777216;

    localparam logic [CNT_W-1:0] COUNTER_TOP = 25'h1000000;
    localparam logic [NUM_W-1:0] NUM_MAX     = 24'hFFFFFF;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_ITEM_LOG = 3'd1;
    localparam logic [2:0] REG_KEY_VAL  = 3'd2;
    localparam logic [2:0] REG_KEY_LEN  = 3'd3;
    localparam logic [2:0] REG_ZERO_T   = 3'd4;

    typedef enum logic [1:0] {
        FUNC_DECODE = 2'd0,
        FUNC_KEY_WR = 2'd1,
        FUNC_START  = 2'd2,
        FUNC_RSVD   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CLS_DECODE = 2'd0,
        CLS_KEY_WR = 2'd1,
        CLS_START  = 2'd2,
        CLS_NOP    = 2'd3
    } cls_t;

    typedef enum logic [2:0] {
        MODE_ROL   = 3'd0,
        MODE_ADD   = 3'd1,
        MODE_SUB   = 3'd2,
        MODE_XOR   = 3'd3,
        MODE_MUL   = 3'd4,
        MODE_RXOR  = 3'd5,
        MODE_XSTR  = 3'd6,
        MODE_SUBST = 3'd7
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [1:0]         item_size_log;
        logic [VAL_W-1:0]   key_value;
        logic [KLEN_W-1:0]  key_length;
        logic               zero_terminated;
    } cfg_t;

    typedef struct packed {
        cls_t             cls;
        logic [VAL_W-1:0] value;
        logic [7:0]       key_index;
        logic [7:0]       key_byte;
        logic             is_zero;
    } qent_t;

    function automatic logic [VAL_W-1:0] width_mask(input logic [1:0] isl);
        logic [VAL_W-1:0] m;
        unique case (isl)
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/mmsd_if.sv
// ----------------------------------------------------------------------------
// mmsd_in_if / mmsd_out_if
// Valid/ready channels for requests and decoded results.
// ----------------------------------------------------------------------------
interface mmsd_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               func;
    logic [mmsd_pkg::VAL_W-1:0] item_value;
    logic [7:0]               key_index;
    logic [7:0]               key_byte;

    modport source (output valid, func, item_value, key_index, key_byte, input ready);
    modport sink   (input valid, func, item_value, key_index, key_byte, output ready);
endinterface

interface mmsd_out_if;
    logic                       valid;
    logic                       ready;
    logic [mmsd_pkg::VAL_W-1:0] out_value;
    logic [mmsd_pkg::NUM_W-1:0] item_number;
    logic                       end_of_string;

    modport source (output valid, out_value, item_number, end_of_string, input ready);
    modport sink   (input valid, out_value, item_number, end_of_string, output ready);
endinterface

// File: rtl/mmsd_front.sv
// ----------------------------------------------------------------------------
// mmsd_front
// Request intake: registers each request, classifies it, trims the value.
// ----------------------------------------------------------------------------
module mmsd_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    mmsd_in_if.sink                in_ch,
    input  mmsd_pkg::cfg_t         cfg,
    output logic                   push_vld,
    output mmsd_pkg::qent_t        push_data,
    input  logic                   push_rdy
);

    logic                stage_vld_reg;
    mmsd_pkg::qent_t     stage_reg;
    mmsd_pkg::qent_t     cls_ent;
    logic [mmsd_pkg::VAL_W-1:0] masked;

    assign in_ch.ready = !stage_vld_reg || push_rdy;
    assign push_vld    = stage_vld_reg;
    assign push_data   = stage_reg;

    always_comb
    begin
        masked            = in_ch.item_value & mmsd_pkg::width_mask(cfg.item_size_log);
        cls_ent.value     = masked;
        cls_ent.key_index = in_ch.key_index;
        cls_ent.key_byte  = in_ch.key_byte;
        cls_ent.is_zero   = (masked == '0);
        unique case (in_ch.func)
            mmsd_pkg::FUNC_DECODE: cls_ent.cls = mmsd_pkg::CLS_DECODE;
            mmsd_pkg::FUNC_KEY_WR: cls_ent.cls = mmsd_pkg::CLS_KEY_WR;
            mmsd_pkg::FUNC_START:  cls_ent.cls = mmsd_pkg::CLS_START;
            default:               cls_ent.cls = mmsd_pkg::CLS_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            stage_vld_reg <= 1'b1;
        end
        else if (push_rdy)
        begin
            stage_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            stage_reg <= cls_ent;
        end
    end

endmodule

// File: rtl/mmsd_queue.sv
// ----------------------------------------------------------------------------
// mmsd_queue
// Two-entry request queue between intake and execution.
// ----------------------------------------------------------------------------
module mmsd_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_vld,
    input  mmsd_pkg::qent_t   push_data,
    output logic              push_rdy,
    output logic              pop_vld,
    output mmsd_pkg::qent_t   pop_data,
    input  logic              pop_rdy
);

    localparam int PTR_W = $clog2(mmsd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mmsd_pkg::QUEUE_DEPTH + 1);

    mmsd_pkg::qent_t   entry_reg [mmsd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_rdy = (count_reg != CNT_W'(mmsd_pkg::QUEUE_DEPTH));
    assign pop_vld  = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push_vld && push_rdy;
    assign do_pop   = pop_vld && pop_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(mmsd_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(mmsd_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/mmsd_back.sv
// ----------------------------------------------------------------------------
// mmsd_back
// Execution sequencer: string state, key table, remainder and multiply units,
// result register.
// ----------------------------------------------------------------------------
module mmsd_back
#(
    parameter int KEY_BYTES        = mmsd_pkg::KEY_BYTES_DEF,
    parameter int MAX_STRING_BYTES = mmsd_pkg::MAX_STRING_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  mmsd_pkg::cfg_t    cfg,
    input  logic              head_vld,
    input  mmsd_pkg::qent_t   head,
    output logic              pop,
    mmsd_out_if.source        out_ch
);

    localparam int KEY_DEPTH = (KEY_BYTES < 256) ? KEY_BYTES : 256;
    localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam logic [mmsd_pkg::KLEN_W-1:0] KEY_TOP = mmsd_pkg::KLEN_W'(KEY_DEPTH);
    localparam logic [mmsd_pkg::CNT_W-1:0]  LIMIT_BASE =
        mmsd_pkg::CNT_W'(MAX_STRING_BYTES);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_TBL  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;
    logic [mmsd_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [31:0]                    roll_reg, roll_next;
    logic [mmsd_pkg::VAL_W-1:0]     val_reg, val_next;
    logic [mmsd_pkg::VAL_W-1:0]     res_reg, res_next;
    logic [mmsd_pkg::NUM_W-1:0]     num_reg, num_next;
    logic                           eos_reg, eos_next;
    logic [mmsd_pkg::VAL_W-1:0]     div_reg, div_next;
    logic [7:0]                     rem_reg, rem_next;
    logic [5:0]                     step_reg, step_next;
    logic [7:0]                     pos_reg, pos_next;
    logic                           prime_reg, prime_next;
    logic [2:0]                     byte_cnt_reg, byte_cnt_next;
    logic [mmsd_pkg::VAL_W-1:0]     word_reg, word_next;
    logic [mmsd_pkg::VAL_W-1:0]     prod_reg, prod_next;
    logic [mmsd_pkg::VAL_W-1:0]     acc_reg, acc_next;
    logic [1:0]                     mstep_reg, mstep_next;
    logic                           ovld_reg, ovld_next;
    logic [mmsd_pkg::VAL_W-1:0]     oval_reg, oval_next;
    logic [mmsd_pkg::NUM_W-1:0]     onum_reg, onum_next;
    logic                           oeos_reg, oeos_next;
    logic [7:0]                     rdata_reg;
    logic [7:0]                     key_mem [KEY_DEPTH];

    logic                           mem_we;
    logic [mmsd_pkg::VAL_W-1:0]     mask;
    logic [mmsd_pkg::KLEN_W-1:0]    len_act;
    logic [mmsd_pkg::CNT_W-1:0]     limit;
    logic [mmsd_pkg::NUM_W-1:0]     pos_out;
    logic [8:0]                     rem_try;
    logic [8:0]                     pos_p1;
    logic [2:0]                     last_byte;
    logic [mmsd_pkg::VAL_W-1:0]     word_ins;
    logic [31:0]                    mul_a;
    logic [31:0]                    mul_b;
    logic [mmsd_pkg::VAL_W-1:0]     acc_sum;

    function automatic logic [63:0] rotl(input logic [63:0] v, input logic [1:0] isl,
                                         input logic [7:0] k);
        logic [15:0]  t8;
        logic [31:0]  t16;
        logic [63:0]  t32;
        logic [127:0] t64;
        logic [63:0]  r;
        t8  = {v[7:0], v[7:0]} << k[2:0];
        t16 = {v[15:0], v[15:0]} << k[3:0];
        t32 = {v[31:0], v[31:0]} << k[4:0];
        t64 = {v, v} << k[5:0];
        unique case (isl)
            2'd0:    r = {56'b0, t8[15:8]};
            2'd1:    r = {48'b0, t16[31:16]};
            2'd2:    r = {32'b0, t32[63:32]};
            default: r = t64[127:64];
        endcase
        return r;
    endfunction

    assign out_ch.valid         = ovld_reg;
    assign out_ch.out_value     = oval_reg;
    assign out_ch.item_number   = onum_reg;
    assign out_ch.end_of_string = oeos_reg;

    always_comb
    begin
        mask    = mmsd_pkg::width_mask(cfg.item_size_log);
        limit   = LIMIT_BASE >> cfg.item_size_log;
        pos_out = (cnt_reg > mmsd_pkg::CNT_W'(mmsd_pkg::NUM_MAX)) ?
                  mmsd_pkg::NUM_MAX : cnt_reg[mmsd_pkg::NUM_W-1:0];
        if (cfg.key_length == '0)
        begin
            len_act = mmsd_pkg::KLEN_W'(1);
        end
        else if (cfg.key_length > KEY_TOP)
        begin
            len_act = KEY_TOP;
        end
        else
        begin
            len_act = cfg.key_length;
        end
        unique case (cfg.item_size_log)
            2'd0:    last_byte = 3'd0;
            2'd1:    last_byte = 3'd1;
            2'd2:    last_byte = 3'd3;
            default: last_byte = 3'd7;
        endcase
        rem_try  = {rem_reg, div_reg[63]};
        pos_p1   = {1'b0, pos_reg} + 9'd1;
        word_ins = word_reg;
        word_ins[{byte_cnt_reg, 3'b000} +: 8] = rdata_reg;
        mul_a    = (mstep_reg == 2'd2) ? val_reg[63:32] : val_reg[31:0];
        mul_b    = (mstep_reg == 2'd1) ? cfg.key_value[63:32] : cfg.key_value[31:0];
        acc_sum  = acc_reg + {prod_reg[31:0], 32'b0};
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        done_next     = done_reg;
        roll_next     = roll_reg;
        val_next      = val_reg;
        res_next      = res_reg;
        num_next      = num_reg;
        eos_next      = eos_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        pos_next      = pos_reg;
        prime_next    = prime_reg;
        byte_cnt_next = byte_cnt_reg;
        word_next     = word_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        mstep_next    = mstep_reg;
        ovld_next     = ovld_reg;
        oval_next     = oval_reg;
        onum_next     = onum_reg;
        oeos_next     = oeos_reg;
        pop           = 1'b0;
        mem_we        = 1'b0;

        if (ovld_reg && out_ch.ready)
        begin
            ovld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_vld)
                begin
                    pop = 1'b1;
                    unique case (head.cls)
                        mmsd_pkg::CLS_KEY_WR:
                        begin
                            mem_we = (32'(head.key_index) < KEY_BYTES);
                        end
                        mmsd_pkg::CLS_START:
                        begin
                            cnt_next  = '0;
                            done_next = 1'b0;
                            roll_next = cfg.key_value[31:0];
                        end
                        mmsd_pkg::CLS_DECODE:
                        begin
                            if (!done_reg)
                            begin
                                val_next  = head.value;
                                num_next  = pos_out;
                                eos_next  = 1'b0;
                                rem_next  = '0;
                                step_next = '0;
                                mstep_next = '0;
                                if (cfg.zero_terminated && (head.is_zero || cnt_reg >= limit))
                                begin
                                    done_next  = 1'b1;
                                    eos_next   = 1'b1;
                                    res_next   = '0;
                                    state_next = ST_EMIT;
                                end
                                else
                                begin
                                    if (cnt_reg < mmsd_pkg::COUNTER_TOP)
                                    begin
                                        cnt_next = cnt_reg + 1'b1;
                                    end
                                    state_next = ST_EMIT;
                                    unique case (cfg.mode)
                                        mmsd_pkg::MODE_ROL:
                                            res_next = rotl(head.value, cfg.item_size_log,
                                                            cfg.key_value[7:0]);
                                        mmsd_pkg::MODE_ADD:
                                            res_next = (head.value + cfg.key_value) & mask;
                                        mmsd_pkg::MODE_SUB:
                                            res_next = (cfg.key_value - head.value) & mask;
                                        mmsd_pkg::MODE_XOR:
                                            res_next = (head.value ^ cfg.key_value) & mask;
                                        mmsd_pkg::MODE_RXOR:
                                        begin
                                            res_next  = (head.value ^
                                                         {cfg.key_value[63:32], roll_reg}) & mask;
                                            roll_next = {roll_reg[30:0], roll_reg[31]};
                                        end
                                        mmsd_pkg::MODE_MUL:
                                            state_next = ST_MUL;
                                        mmsd_pkg::MODE_XSTR:
                                        begin
                                            div_next   = mmsd_pkg::VAL_W'(cnt_reg);
                                            state_next = ST_DIV;
                                        end
                                        default:
                                        begin
                                            div_next   = head.value;
                                            state_next = ST_DIV;
                                        end
                                    endcase
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (rem_try >= len_act)
                begin
                    rem_next = 8'(rem_try - len_act);
                end
                else
                begin
                    rem_next = rem_try[7:0];
                end
                div_next  = {div_reg[62:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == 6'd63)
                begin
                    pos_next      = rem_next;
                    prime_next    = 1'b0;
                    byte_cnt_next = '0;
                    word_next     = '0;
                    state_next    = ST_TBL;
                end
            end
            ST_TBL:
            begin
                pos_next   = (pos_p1 == len_act) ? '0 : pos_p1[7:0];
                prime_next = 1'b1;
                if (prime_reg)
                begin
                    word_next     = word_ins;
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                    if (byte_cnt_reg == last_byte)
                    begin
                        res_next   = (cfg.mode == mmsd_pkg::MODE_XSTR) ?
                                     ((val_reg ^ word_ins) & mask) : (word_ins & mask);
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = mul_a * mul_b;
                mstep_next = mstep_reg + 1'b1;
                unique case (mstep_reg)
                    2'd0:    acc_next = '0;
                    2'd1:    acc_next = prod_reg;
                    2'd2:    acc_next = acc_sum;
                    default:
                    begin
                        res_next   = acc_sum & mask;
                        state_next = ST_EMIT;
                    end
                endcase
            end
            default:
            begin
                if (!ovld_reg || out_ch.ready)
                begin
                    ovld_next  = 1'b1;
                    oval_next  = res_reg;
                    onum_next  = num_reg;
                    oeos_next  = eos_reg;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            roll_reg  <= '0;
            ovld_reg  <= 1'b0;
            step_reg  <= '0;
            mstep_reg <= '0;
            prime_reg <= 1'b0;
            byte_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            roll_reg  <= roll_next;
            ovld_reg  <= ovld_next;
            step_reg  <= step_next;
            mstep_reg <= mstep_next;
            prime_reg <= prime_next;
            byte_cnt_reg <= byte_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        res_reg  <= res_next;
        num_reg  <= num_next;
        eos_reg  <= eos_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        pos_reg  <= pos_next;
        word_reg <= word_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        oval_reg <= oval_next;
        onum_reg <= onum_next;
        oeos_reg <= oeos_next;
    end

    // key table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[head.key_index[KEY_AW-1:0]] <= head.key_byte;
        end
        rdata_reg <= key_mem[pos_reg[KEY_AW-1:0]];
    end

endmodule

// File: rtl/multi_mode_string_deobfuscator_unit.sv
// ----------------------------------------------------------------------------
// multi_mode_string_deobfuscator_unit
// Multi-mode string item decoder with key table and APB register port.
// ----------------------------------------------------------------------------
// Requests enter on in_ch (valid/ready): func selects decode, key table byte
// write, or start of a new string. Decoded items leave on out_ch with their
// position in the string and an end-of-string flag for the terminator.
// Mode, item size, key value, key length and zero termination are set over
// the APB port at byte address 8*i; the user must write them only while no
// request is in flight, which the block itself does not enforce. A request
// is registered and classified, then waits in a two-entry queue for the
// execution sequencer. Rotate, add, sub, xor, rotating xor and terminators
// are decoded directly; multiply sums three 32x32 partial products, and the
// key table modes run a one-bit-per-cycle remainder loop (64 steps) and then
// fetch the key bytes through the single key table read port. The sequencer
// takes the next request from the queue only after passing the previous
// result to the output register. No clearing pass is needed after reset.
// Reset clears the string counter, rolling key and queue and restores the
// register defaults; key table contents are undefined until written. When
// out_ch stalls, the sequencer holds one more result behind the one on
// out_ch, and the queue and intake stage still take three requests.
// ----------------------------------------------------------------------------
module multi_mode_string_deobfuscator_unit
#(
    parameter int KEY_BYTES        = mmsd_pkg::KEY_BYTES_DEF,
    parameter int MAX_STRING_BYTES = mmsd_pkg::MAX_STRING_BYTES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    mmsd_in_if.sink                        in_ch,
    mmsd_out_if.source                     out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mmsd_pkg::PADDR_W-1:0]   paddr,
    input  logic [mmsd_pkg::PDATA_W-1:0]   pwdata,
    output logic [mmsd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    mmsd_pkg::cfg_t   cfg_reg;
    logic             wr_en;
    logic [2:0]       reg_idx;
    logic             push_vld;
    logic             push_rdy;
    mmsd_pkg::qent_t  push_data;
    logic             head_vld;
    mmsd_pkg::qent_t  head;
    logic             pop;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode            <= mmsd_pkg::MODE_ROL;
            cfg_reg.item_size_log   <= '0;
            cfg_reg.key_value       <= '0;
            cfg_reg.key_length      <= mmsd_pkg::KLEN_W'(1);
            cfg_reg.zero_terminated <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                mmsd_pkg::REG_MODE:     cfg_reg.mode <= mmsd_pkg::mode_t'(pwdata[2:0]);
                mmsd_pkg::REG_ITEM_LOG: cfg_reg.item_size_log <= pwdata[1:0];
                mmsd_pkg::REG_KEY_VAL:  cfg_reg.key_value <= pwdata;
                mmsd_pkg::REG_KEY_LEN:  cfg_reg.key_length <= pwdata[mmsd_pkg::KLEN_W-1:0];
                mmsd_pkg::REG_ZERO_T:   cfg_reg.zero_terminated <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            mmsd_pkg::REG_MODE:     prdata = mmsd_pkg::PDATA_W'(cfg_reg.mode);
            mmsd_pkg::REG_ITEM_LOG: prdata = mmsd_pkg::PDATA_W'(cfg_reg.item_size_log);
            mmsd_pkg::REG_KEY_VAL:  prdata = cfg_reg.key_value;
            mmsd_pkg::REG_KEY_LEN:  prdata = mmsd_pkg::PDATA_W'(cfg_reg.key_length);
            mmsd_pkg::REG_ZERO_T:   prdata = mmsd_pkg::PDATA_W'(cfg_reg.zero_terminated);
            default:                prdata = '0;
        endcase
    end

    mmsd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg_reg),
        .push_vld  (push_vld),
        .push_data (push_data),
        .push_rdy  (push_rdy)
    );

    mmsd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_vld  (push_vld),
        .push_data (push_data),
        .push_rdy  (push_rdy),
        .pop_vld   (head_vld),
        .pop_data  (head),
        .pop_rdy   (pop)
    );

    mmsd_back
    #(
        .KEY_BYTES        (KEY_BYTES),
        .MAX_STRING_BYTES (MAX_STRING_BYTES)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .head_vld (head_vld),
        .head     (head),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-mode string deobfuscator unit.
// Requests are queued by a stimulus process and fed to the request channel by
// a clocked driver with random gaps. Each accepted request runs through a
// decoder model kept in the bench, and the expected decoded items are
// compared field by field with what the result channel delivers under random
// back-pressure. The APB port switches mode, item size, key value, key length
// and zero termination between phases, always with nothing in flight.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RAND_ITEMS    = 1250;
    localparam int          PHASE_ITEMS   = 60;
    localparam int          SETTLE_CYCLES = 120;
    localparam int unsigned STR_LIMIT     = mmsd_pkg::MAX_STRING_BYTES_DEF;

    typedef struct packed {
        mmsd_pkg::func_t func;
        logic [63:0]     item_value;
        logic [7:0]      key_index;
        logic [7:0]      key_byte;
    } req_t;

    typedef struct packed {
        logic [63:0] value;
        logic [23:0] number;
        logic        eos;
    } dec_result_t;

    logic clk;
    logic rst_n;

    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [mmsd_pkg::PADDR_W-1:0]  paddr;
    logic [mmsd_pkg::PDATA_W-1:0]  pwdata;
    logic [mmsd_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    mmsd_in_if  req_ch();
    mmsd_out_if res_ch();

    multi_mode_string_deobfuscator_unit u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (req_ch),
        .out_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // register shadow
    mmsd_pkg::mode_t sh_mode;
    logic [1:0]      sh_isl;
    logic [63:0]     sh_key;
    logic [8:0]      sh_klen;
    logic            sh_zt;

    // decoder state
    logic [7:0]  key_tbl [256];
    logic [24:0] str_pos;
    logic [31:0] roll_key;
    logic        str_done;

    req_t        req_pending [$];
    dec_result_t decoded_q [$];
    req_t        req_cur;

    int tx_idle;
    int rx_idle;
    int sent_cnt;
    int acc_cnt;
    int counted_items;
    int results_checked;
    int terminators;
    int key_writes;
    int cfg_count;
    int err_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [63:0] key_word(input logic [63:0] start, input int unsigned len,
                                             input int unsigned nbytes);
        logic [63:0] w;
        int unsigned p;
        w = '0;
        for (int b = 0; b < nbytes; b++)
        begin
            p = int'((start + 64'(b)) % 64'(len));
            w |= 64'(key_tbl[p]) << (8 * b);
        end
        return w;
    endfunction

    task automatic decode_request(input req_t r);
        int unsigned nbytes;
        int unsigned width;
        int unsigned len;
        int unsigned sh;
        logic [63:0] m;
        logic [63:0] v;
        logic [63:0] res;
        logic [23:0] pos_out;
        dec_result_t e;
        nbytes = 1 << sh_isl;
        width  = 8 * nbytes;
        m      = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
        v      = r.item_value & m;
        res    = '0;
        case (r.func)
            mmsd_pkg::FUNC_KEY_WR:
            begin
                key_tbl[r.key_index] = r.key_byte;
                key_writes++;
            end
            mmsd_pkg::FUNC_START:
            begin
                str_pos  = '0;
                str_done = 1'b0;
                roll_key = sh_key[31:0];
            end
            mmsd_pkg::FUNC_DECODE:
            begin
                if (!str_done)
                begin
                    pos_out = (str_pos > 25'hFFFFFF) ? 24'hFFFFFF : str_pos[23:0];
                    if (sh_zt && (v == '0 || int'(str_pos) >= int'(STR_LIMIT >> sh_isl)))
                    begin
                        str_done = 1'b1;
                        e.value  = '0;
                        e.number = pos_out;
                        e.eos    = 1'b1;
                        decoded_q.push_back(e);
                        terminators++;
                    end
                    else
                    begin
                        len = (sh_klen == 0) ? 1 : sh_klen;
                        if (len > 256)
                            len = 256;
                        case (sh_mode)
                            mmsd_pkg::MODE_ROL:
                            begin
                                sh  = sh_key[7:0] % width;
                                res = (sh == 0) ? v : ((v << sh) | (v >> (width - sh)));
                            end
                            mmsd_pkg::MODE_ADD: res = v + sh_key;
                            mmsd_pkg::MODE_SUB: res = sh_key - v;
                            mmsd_pkg::MODE_XOR: res = v ^ sh_key;
                            mmsd_pkg::MODE_MUL: res = v * sh_key;
                            mmsd_pkg::MODE_RXOR:
                            begin
                                res      = v ^ {sh_key[63:32], roll_key};
                                roll_key = {roll_key[30:0], roll_key[31]};
                            end
                            mmsd_pkg::MODE_XSTR:
                                res = v ^ key_word(64'(str_pos % len), len, nbytes);
                            default:
                                res = key_word(v % 64'(len), len, nbytes);
                        endcase
                        if (str_pos < mmsd_pkg::COUNTER_TOP)
                            str_pos++;
                        e.value  = res & m;
                        e.number = pos_out;
                        e.eos    = 1'b0;
                        decoded_q.push_back(e);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.func       <= mmsd_pkg::FUNC_DECODE;
            req_ch.item_value <= '0;
            req_ch.key_index  <= '0;
            req_ch.key_byte   <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                decode_request(req_cur);
                acc_cnt++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_pending.size() != 0 && $urandom_range(0, 99) >= tx_idle)
                begin
                    req_cur = req_pending.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.func       <= req_cur.func;
                    req_ch.item_value <= req_cur.item_value;
                    req_ch.key_index  <= req_cur.key_index;
                    req_ch.key_byte   <= req_cur.key_byte;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        dec_result_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_checked++;
                if (decoded_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result exp none act %h/%h/%b", $time,
                             res_ch.out_value, res_ch.item_number, res_ch.end_of_string);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (res_ch.out_value !== want.value)
                    begin
                        err_count++;
                        $display("%0t: out_value exp %h act %h", $time,
                                 want.value, res_ch.out_value);
                    end
                    if (res_ch.item_number !== want.number)
                    begin
                        err_count++;
                        $display("%0t: item_number exp %h act %h", $time,
                                 want.number, res_ch.item_number);
                    end
                    if (res_ch.end_of_string !== want.eos)
                    begin
                        err_count++;
                        $display("%0t: end_of_string exp %b act %b", $time,
                                 want.eos, res_ch.end_of_string);
                    end
                end
            end
            res_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    task automatic send(input mmsd_pkg::func_t f, input logic [63:0] v, input logic [7:0] ki,
                        input logic [7:0] kb);
        req_t r;
        r.func       = f;
        r.item_value = v;
        r.key_index  = ki;
        r.key_byte   = kb;
        req_pending.push_back(r);
        sent_cnt++;
    endtask

    // sender holds off until every request is taken and every result is back
    task automatic drain();
        while (acc_cnt != sent_cnt || decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            mmsd_pkg::REG_MODE:     sh_mode = mmsd_pkg::mode_t'(val[2:0]);
            mmsd_pkg::REG_ITEM_LOG: sh_isl  = val[1:0];
            mmsd_pkg::REG_KEY_VAL:  sh_key  = val;
            mmsd_pkg::REG_KEY_LEN:  sh_klen = val[8:0];
            mmsd_pkg::REG_ZERO_T:   sh_zt   = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(input mmsd_pkg::mode_t md, input logic [1:0] isl,
                             input logic [63:0] key, input logic [8:0] klen, input logic zt);
        drain();
        reg_write(mmsd_pkg::REG_MODE, 64'(md));
        reg_write(mmsd_pkg::REG_ITEM_LOG, 64'(isl));
        reg_write(mmsd_pkg::REG_KEY_VAL, key);
        reg_write(mmsd_pkg::REG_KEY_LEN, 64'(klen));
        reg_write(mmsd_pkg::REG_ZERO_T, 64'(zt));
        cfg_count++;
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return 64'($urandom_range(1, 3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // strings of decodes with random content, some noise mixed in
    task automatic gen_phase(input int quota);
        int          got;
        int          n;
        logic        done;
        logic [63:0] v;
        logic [63:0] m;
        got  = 0;
        done = 1'b0;
        m    = (sh_isl == 2'd3) ? '1 : ((64'd1 << (8 << sh_isl)) - 64'd1);
        while (got < quota)
        begin
            if ($urandom_range(0, 9) != 0)
            begin
                send(mmsd_pkg::FUNC_START, {$urandom, $urandom}, 8'($urandom), 8'($urandom));
                done = 1'b0;
                got++;
            end
            n = $urandom_range(1, 12);
            repeat (n)
            begin
                case ($urandom_range(0, 19))
                    0:
                    begin
                        send(mmsd_pkg::FUNC_KEY_WR, {$urandom, $urandom}, 8'($urandom),
                             8'($urandom));
                        got++;
                    end
                    1:
                    begin
                        send(mmsd_pkg::FUNC_RSVD, {$urandom, $urandom}, 8'($urandom),
                             8'($urandom));
                    end
                    default:
                    begin
                        v = rand_value();
                        send(mmsd_pkg::FUNC_DECODE, v, 8'($urandom), 8'($urandom));
                        if (!done)
                            got++;
                        if (sh_zt && (v & m) == '0)
                            done = 1'b1;
                    end
                endcase
            end
            if (sh_zt && $urandom_range(0, 9) < 7)
            begin
                send(mmsd_pkg::FUNC_DECODE, {$urandom, $urandom} & ~m, 8'($urandom),
                     8'($urandom));
                if (!done)
                    got++;
                done = 1'b1;
                repeat ($urandom_range(0, 2))
                    send(mmsd_pkg::FUNC_DECODE, rand_value(), 8'($urandom), 8'($urandom));
            end
        end
        counted_items += got;
    endtask

    initial
    begin
        int          phase;
        logic [63:0] key;
        logic [8:0]  klen;
        rst_n   = 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        sh_mode  = mmsd_pkg::MODE_ROL;
        sh_isl   = 2'd0;
        sh_key   = '0;
        sh_klen  = 9'd1;
        sh_zt    = 1'b0;
        str_pos  = '0;
        roll_key = '0;
        str_done = 1'b0;
        foreach (key_tbl[i])
            key_tbl[i] = '0;
        tx_idle = 25;
        rx_idle = 59;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // fill the whole key table so no decode reads an unwritten entry
        for (int i = 0; i < 256; i++)
            send(mmsd_pkg::FUNC_KEY_WR, {$urandom, $urandom}, 8'(i),
                 (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom));

        // directed
        apply_cfg(mmsd_pkg::MODE_ROL, 2'd3, '1, 9'd1, 1'b0);
        send(mmsd_pkg::FUNC_START, '0, '0, '0);
        send(mmsd_pkg::FUNC_DECODE, 64'h8000_0000_0000_0001, '0, '0);
        send(mmsd_pkg::FUNC_DECODE, '1, '1, '1);
        send(mmsd_pkg::FUNC_DECODE, '0, '0, '0);
        apply_cfg(mmsd_pkg::MODE_MUL, 2'd3, '1, 9'd256, 1'b0);
        send(mmsd_pkg::FUNC_DECODE, '1, '0, '0);
        send(mmsd_pkg::FUNC_DECODE, 64'h1234_5678_9ABC_DEF0, '0, '0);
        apply_cfg(mmsd_pkg::MODE_SUB, 2'd0, '0, 9'd1, 1'b0);
        send(mmsd_pkg::FUNC_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
        send(mmsd_pkg::FUNC_RSVD, '1, '1, '1);
        // terminator, decode after end, restart
        apply_cfg(mmsd_pkg::MODE_RXOR, 2'd2, 64'h8000_0001_8000_0001, 9'd1, 1'b1);
        send(mmsd_pkg::FUNC_START, '0, '0, '0);
        send(mmsd_pkg::FUNC_DECODE, 64'hFFFF_FFFF, '0, '0);
        send(mmsd_pkg::FUNC_DECODE, 64'h1, '0, '0);
        send(mmsd_pkg::FUNC_DECODE, 64'hFFFF_FFFF_0000_0000, '0, '0);
        send(mmsd_pkg::FUNC_DECODE, 64'h5, '0, '0);
        send(mmsd_pkg::FUNC_START, '0, '0, '0);
        send(mmsd_pkg::FUNC_DECODE, 64'h7, '0, '0);
        // zero key length counts as one
        apply_cfg(mmsd_pkg::MODE_XSTR, 2'd3, '0, 9'd0, 1'b0);
        send(mmsd_pkg::FUNC_START, '0, '0, '0);
        send(mmsd_pkg::FUNC_DECODE, '1, '0, '0);
        send(mmsd_pkg::FUNC_DECODE, '0, '0, '0);
        // oversized key length clamps, table read wraps
        apply_cfg(mmsd_pkg::MODE_SUBST, 2'd3, '0, 9'd511, 1'b0);
        send(mmsd_pkg::FUNC_KEY_WR, '0, 8'hFF, 8'hA5);
        send(mmsd_pkg::FUNC_DECODE, '1, '0, '0);
        send(mmsd_pkg::FUNC_DECODE, '0, '0, '0);
        apply_cfg(mmsd_pkg::MODE_ADD, 2'd1, '1, 9'd256, 1'b1);
        send(mmsd_pkg::FUNC_START, '0, '0, '0);
        send(mmsd_pkg::FUNC_DECODE, 64'hFFFF, '0, '0);
        send(mmsd_pkg::FUNC_DECODE, 64'h1_0000, '0, '0);
        apply_cfg(mmsd_pkg::MODE_XOR, 2'd2, 64'h5555_5555_5555_5555, 9'd2, 1'b0);
        send(mmsd_pkg::FUNC_DECODE, 64'hAAAA_AAAA_AAAA_AAAA, '0, '0);

        // random phases
        counted_items = 0;
        phase = 0;
        while (counted_items < RAND_ITEMS)
        begin
            if (counted_items < RAND_ITEMS / 3)
            begin
                tx_idle = 25;
                rx_idle = 59;
            end
            else if (counted_items < 2 * RAND_ITEMS / 3)
            begin
                tx_idle = 59;
                rx_idle = 25;
            end
            else
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            case ($urandom_range(0, 5))
                0:       key = '0;
                1:       key = '1;
                2:       key = 64'h8000_0000_0000_0000;
                3:       key = 64'($urandom_range(1, 255));
                4:       key = {32'h0, $urandom};
                default: key = {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 7))
                0:       klen = 9'd0;
                1:       klen = 9'd1;
                2:       klen = 9'd256;
                3:       klen = 9'd511;
                4:       klen = 9'($urandom_range(257, 510));
                5:       klen = 9'($urandom_range(2, 17));
                default: klen = 9'($urandom_range(1, 256));
            endcase
            apply_cfg(mmsd_pkg::mode_t'(3'(phase)), 2'($urandom_range(0, 3)), key, klen,
                      1'($urandom_range(0, 1)));
            gen_phase(PHASE_ITEMS);
            phase++;
        end
        drain();

        $display("Run covered %0d accepted requests and %0d checked results (%0d terminators)",
                 acc_cnt, results_checked, terminators);
        $display("across %0d register settings of all modes and item sizes, %0d key writes",
                 cfg_count, key_writes);
        if (err_count == 0 && decoded_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
